/* src/telemetry_frame_builder_crc8_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the telemetry frame builder
// Shared concurrent assertion forms, clocked on the rising edge and held off
// while reset is high.
// ----------------------------------------------------------------------------
`ifndef TELEMETRY_FRAME_BUILDER_CRC8_CORE_MACROS_SVH
`define TELEMETRY_FRAME_BUILDER_CRC8_CORE_MACROS_SVH

// Same-cycle implication.
`define TFB_ASSERT_IMP(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("tfb assertion failed");

// Next-cycle implication.
`define TFB_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("tfb assertion failed");

`endif

/* src/tfb_pkg.sv */
// ----------------------------------------------------------------------------
// tfb_pkg
// Types, codes and the CRC-8 step shared by the frame builder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tfb_pkg;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MAGIC_FIRST    = 2'd0;
  localparam logic [1:0] REG_MAGIC_SECOND   = 2'd1;
  localparam logic [1:0] REG_FORMAT_VERSION = 2'd2;

  // item function codes
  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_PAYLOAD = 1'b1;

  localparam logic [7:0] CRC_POLY = 8'h07;

  typedef struct packed {
    logic       func;
    logic [7:0] frame_type;
    logic [7:0] seq_number;
    logic [7:0] payload_length;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_frame;
  } byte_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_kind_t;

  // one classified command: a frame start or one payload byte
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] b0;     // frame type for a start, data byte for payload
    logic [7:0] seq;
    logic [7:0] len;
    logic       close;  // start of zero length, or last payload byte
  } cmd_t;

  // CRC-8, poly 0x07, MSB first, one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/tfb_if.sv */
// ----------------------------------------------------------------------------
// tfb stream interfaces
// Valid/ready channels for input items and output frame bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfb_item_if;
  logic            valid;
  logic            ready;
  tfb_pkg::item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tfb_byte_if;
  logic            valid;
  logic            ready;
  tfb_pkg::byte_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* src/tfb_front.sv */
// ----------------------------------------------------------------------------
// tfb_front
// Accepts items, tracks the open frame and pushes classified commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tfb_front (
  input  wire logic           clk,
  input  wire logic           rst,
  tfb_item_if.sink            item_ch,
  output tfb_pkg::cmd_t       push_cmd,
  output logic                push,
  input  wire logic           q_full
);

  logic [7:0] remaining;
  logic [7:0] remaining_next;
  logic       accept;

  assign item_ch.ready = !q_full;
  assign accept        = item_ch.valid && !q_full;

  always_comb begin
    push           = 1'b0;
    remaining_next = remaining;
    push_cmd.kind  = tfb_pkg::CMD_DATA;
    push_cmd.b0    = item_ch.payload.data_byte;
    push_cmd.seq   = item_ch.payload.seq_number;
    push_cmd.len   = item_ch.payload.payload_length;
    push_cmd.close = 1'b0;
    priority if (accept && item_ch.payload.func == tfb_pkg::FUNC_START) begin
      push           = 1'b1;
      push_cmd.kind  = tfb_pkg::CMD_START;
      push_cmd.b0    = item_ch.payload.frame_type;
      push_cmd.close = (item_ch.payload.payload_length == 8'd0);
      remaining_next = item_ch.payload.payload_length;
    end else if (accept && remaining != 8'd0) begin
      // payload inside an open frame; with no open frame drop it
      push           = 1'b1;
      push_cmd.close = (remaining == 8'd1);
      remaining_next = remaining - 8'd1;
    end else begin
      remaining_next = remaining;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= 8'd0;
    end else begin
      remaining <= remaining_next;
    end
  end

endmodule

`default_nettype wire

/* src/tfb_queue.sv */
// ----------------------------------------------------------------------------
// tfb_queue
// Small command FIFO between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

`include "telemetry_frame_builder_crc8_core_macros.svh"

module tfb_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tfb_pkg::cmd_t  push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output tfb_pkg::cmd_t       head_cmd
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tfb_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  `TFB_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `TFB_ASSERT_IMP(a_no_pop_empty, clk, rst, pop, count != '0)
  `TFB_ASSERT_NEXT(a_push_lands, clk, rst, push && !pop, count != '0)

endmodule

`default_nettype wire

/* src/tfb_back.sv */
// ----------------------------------------------------------------------------
// tfb_back
// Expands commands into frame bytes, folds the CRC and drives the output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "telemetry_frame_builder_crc8_core_macros.svh"

module tfb_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [7:0]     magic_first,
  input  wire logic [7:0]     magic_second,
  input  wire logic [7:0]     format_version,
  input  wire logic           q_valid,
  input  wire tfb_pkg::cmd_t  q_cmd,
  output logic                q_pop,
  tfb_byte_if.source          byte_ch
);

  typedef enum logic [6:0] {
    ST_FETCH   = 7'b0000001,
    ST_MAGIC2  = 7'b0000010,
    ST_VERSION = 7'b0000100,
    ST_TYPE    = 7'b0001000,
    ST_SEQ     = 7'b0010000,
    ST_LEN     = 7'b0100000,
    ST_CRC     = 7'b1000000
  } state_t;

  state_t     state;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_eof;
  logic [7:0] crc;
  logic [7:0] hdr_type;
  logic [7:0] hdr_seq;
  logic [7:0] hdr_len;
  logic       hdr_close;
  logic       adv;

  assign adv                          = !out_valid || byte_ch.ready;
  assign q_pop                        = adv && (state == ST_FETCH) && q_valid;
  assign byte_ch.valid                = out_valid;
  assign byte_ch.payload.out_byte     = out_byte;
  assign byte_ch.payload.end_of_frame = out_eof;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FETCH;
      out_valid <= 1'b0;
      crc       <= 8'd0;
    end else if (adv) begin
      unique case (state)
        ST_FETCH: begin
          out_valid <= q_valid;
          out_eof   <= 1'b0;
          if (q_valid) begin
            if (q_cmd.kind == tfb_pkg::CMD_START) begin
              out_byte  <= magic_first;
              hdr_type  <= q_cmd.b0;
              hdr_seq   <= q_cmd.seq;
              hdr_len   <= q_cmd.len;
              hdr_close <= q_cmd.close;
              crc       <= 8'd0;
              state     <= ST_MAGIC2;
            end else begin
              out_byte <= q_cmd.b0;
              crc      <= tfb_pkg::crc8_step(crc, q_cmd.b0);
              state    <= q_cmd.close ? ST_CRC : ST_FETCH;
            end
          end
        end
        ST_MAGIC2: begin
          out_valid <= 1'b1;
          out_eof   <= 1'b0;
          out_byte  <= magic_second;
          state     <= ST_VERSION;
        end
        ST_VERSION: begin
          out_valid <= 1'b1;
          out_eof   <= 1'b0;
          out_byte  <= format_version;
          crc       <= tfb_pkg::crc8_step(crc, format_version);
          state     <= ST_TYPE;
        end
        ST_TYPE: begin
          out_valid <= 1'b1;
          out_eof   <= 1'b0;
          out_byte  <= hdr_type;
          crc       <= tfb_pkg::crc8_step(crc, hdr_type);
          state     <= ST_SEQ;
        end
        ST_SEQ: begin
          out_valid <= 1'b1;
          out_eof   <= 1'b0;
          out_byte  <= hdr_seq;
          crc       <= tfb_pkg::crc8_step(crc, hdr_seq);
          state     <= ST_LEN;
        end
        ST_LEN: begin
          out_valid <= 1'b1;
          out_eof   <= 1'b0;
          out_byte  <= hdr_len;
          crc       <= tfb_pkg::crc8_step(crc, hdr_len);
          state     <= hdr_close ? ST_CRC : ST_FETCH;
        end
        ST_CRC: begin
          out_valid <= 1'b1;
          out_eof   <= 1'b1;
          out_byte  <= crc;
          state     <= ST_FETCH;
        end
        default: begin
          out_valid <= 1'b0;
          state     <= ST_FETCH;
        end
      endcase
    end
  end

  `TFB_ASSERT_NEXT(a_crc_closes, clk, rst, adv && state == ST_CRC,
                   out_valid && out_eof && state == ST_FETCH)
  `TFB_ASSERT_IMP(a_pop_in_fetch, clk, rst, q_pop, state == ST_FETCH)
  `TFB_ASSERT_NEXT(a_header_open, clk, rst, q_pop && q_cmd.kind == tfb_pkg::CMD_START,
                   out_valid && !out_eof && state == ST_MAGIC2)

endmodule

`default_nettype wire

/* src/telemetry_frame_builder_crc8_core.sv */
// ----------------------------------------------------------------------------
// telemetry_frame_builder_crc8_core
// Turns start and payload items into framed telemetry bytes with a CRC-8.
// ----------------------------------------------------------------------------
// A start item (func 0) produces the six header bytes magic_first,
// magic_second, format_version, frame_type, seq_number and payload_length,
// one per output beat; a zero-length start adds the closing CRC beat right
// after the header. Each payload item (func 1) of an open frame produces one
// beat carrying its data byte, and the last one is followed by the CRC beat
// with end_of_frame set. The CRC is CRC-8, polynomial 0x07, init 0, MSB
// first, no final xor, over the version byte through the last payload byte.
// Payload with no open frame is taken and dropped; a start restarts any
// open frame without a CRC. Timing: the output emits one beat per cycle
// while byte_ch.ready is high and commands are queued. The back end
// drives a single registered output byte. The front takes an item every
// cycle as long as the command queue (QUEUE_DEPTH entries) has room, so
// payload items can enter the queue while a header is still emitted,
// until it fills. Configuration registers sit at byte addresses 0x0,
// 0x4 and 0x8 and are to be written only while the block is idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module telemetry_frame_builder_crc8_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tfb_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [tfb_pkg::PDATA_W-1:0]   pwdata,
  output logic      [tfb_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  tfb_item_if.sink                           item_ch,
  tfb_byte_if.source                         byte_ch
);

  // configuration registers
  logic [7:0] magic_first;
  logic [7:0] magic_second;
  logic [7:0] format_version;
  logic [1:0] reg_idx;
  logic       cfg_write;
  logic [7:0] rd_byte;

  // front to queue, queue to back
  tfb_pkg::cmd_t push_cmd;
  logic          push;
  logic          q_full;
  tfb_pkg::cmd_t head_cmd;
  logic          head_valid;
  logic          pop;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite;

  // write at the access phase; an index past the last register is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      magic_first    <= 8'd0;
      magic_second   <= 8'd0;
      format_version <= 8'd0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        tfb_pkg::REG_MAGIC_FIRST:    magic_first    <= pwdata[7:0];
        tfb_pkg::REG_MAGIC_SECOND:   magic_second   <= pwdata[7:0];
        tfb_pkg::REG_FORMAT_VERSION: format_version <= pwdata[7:0];
        default: begin
          magic_first <= magic_first;
        end
      endcase
    end
  end

  // readback of the addressed register, zero past the list
  always_comb begin
    unique case (reg_idx)
      tfb_pkg::REG_MAGIC_FIRST:    rd_byte = magic_first;
      tfb_pkg::REG_MAGIC_SECOND:   rd_byte = magic_second;
      tfb_pkg::REG_FORMAT_VERSION: rd_byte = format_version;
      default:                     rd_byte = 8'd0;
    endcase
    prdata = {{(tfb_pkg::PDATA_W - 8){1'b0}}, rd_byte};
  end

  // classify items and track the open frame
  tfb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .item_ch  (item_ch),
    .push_cmd (push_cmd),
    .push     (push),
    .q_full   (q_full)
  );

  // decouple the item side from the byte side
  tfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // expand commands into beats and fold the CRC
  tfb_back u_back (
    .clk            (clk),
    .rst            (rst),
    .magic_first    (magic_first),
    .magic_second   (magic_second),
    .format_version (format_version),
    .q_valid        (head_valid),
    .q_cmd          (head_cmd),
    .q_pop          (pop),
    .byte_ch        (byte_ch)
  );

endmodule

`default_nettype wire
